### design/dbrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrt_pkg
// Shared widths, constants, register indexes and types of the depth
// back-projection and rigid-transform pipeline.
// ----------------------------------------------------------------------------
package dbrt_pkg;

  // depth map geometry, projection centre is half of each
  localparam int DEPTH_ROWS = 512;
  localparam int DEPTH_COLS = 1024;

  // item fields
  localparam int ROW_W      = 9;
  localparam int COL_W      = 10;
  localparam int DEPTH_IN_W = 17;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 12;
  localparam int POINT_W    = 32;

  // Q8.8 clamp thresholds: 150.0 and 160.0
  localparam int DEPTH_LIMIT = 38400;
  localparam int DEPTH_FAR   = 40960;
  localparam int COLOR_MAX   = 4095;

  // configuration
  localparam int COEF_W      = 18;
  localparam int ROT_W       = 3 * COEF_W;
  localparam int TRANS_W     = 21;
  localparam int TRANS_REG_W = 3 * TRANS_W;
  localparam int FOCAL_W     = 24;
  localparam int SCALE_W     = 16;
  localparam int SCALE_FRAC  = 12;
  localparam int SCALE_ONE   = 1 << SCALE_FRAC;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TRANS_REG_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE   = 3'd6;

  // internal datapath widths
  localparam int DELTA_W    = 13;                       // 2*pos - size, half pixels
  localparam int MD_W       = DELTA_W + DEPTH_W + 1;    // delta * depth
  localparam int FX_W       = MD_W + FOCAL_W + 1;       // delta * depth * inv_focal
  localparam int FOCAL_FRAC = 25;
  localparam int COORD_W    = 28;                       // camera-space x / y, Q.8
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int ROT_FRAC   = 16;
  localparam int CPROD_W    = COL_W + SCALE_W;

  // pipeline: four front-end stages, three transform stages
  localparam int NUM_STAGES = 7;
  localparam int ST_XF_MUL  = 4;
  localparam int ST_XF_SUM  = 5;
  localparam int ST_OUT     = 6;

  typedef logic [NUM_STAGES-1:0]      stage_en_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic [COLOR_W-1:0]         color_t;

endpackage
`default_nettype wire

### design/dbrt_frontend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrt_frontend
// Depth clamp, back-projection about the map centre and colour-image
// coordinates, in four register stages.
// ----------------------------------------------------------------------------
module dbrt_frontend (
  input  logic                                  clk_i,
  input  dbrt_pkg::stage_en_t                   en_i,
  input  logic [dbrt_pkg::ROW_W-1:0]            pixel_row_i,
  input  logic [dbrt_pkg::COL_W-1:0]            pixel_col_i,
  input  logic signed [dbrt_pkg::DEPTH_IN_W-1:0] depth_i,
  input  logic [dbrt_pkg::FOCAL_W-1:0]          inv_focal_i,
  input  logic [dbrt_pkg::SCALE_W-1:0]          row_scale_i,
  input  logic [dbrt_pkg::SCALE_W-1:0]          col_scale_i,
  output logic                                  pv_o,
  output logic [dbrt_pkg::DEPTH_W-1:0]          depth_o,
  output dbrt_pkg::coord_t                      x_o,
  output dbrt_pkg::coord_t                      y_o,
  output dbrt_pkg::color_t                      crow_o,
  output dbrt_pkg::color_t                      ccol_o
);
  import dbrt_pkg::*;

  // round to nearest, saturate at the colour-image limit
  function automatic color_t color_round(input logic [CPROD_W-1:0] p);
    logic [CPROD_W:0] r;
    r = {1'b0, p} + (CPROD_W+1)'(SCALE_ONE / 2);
    if (r[CPROD_W:SCALE_FRAC] > (CPROD_W+1-SCALE_FRAC)'(COLOR_MAX)) begin
      return COLOR_W'(COLOR_MAX);
    end
    return r[SCALE_FRAC+COLOR_W-1:SCALE_FRAC];
  endfunction

  // stage 1: clamp and centre offsets
  logic [DEPTH_W-1:0]        d1_d, d1_q;
  logic signed [DELTA_W:0]   dc_wide, dr_wide;
  logic signed [DELTA_W-1:0] dc1_q, dr1_q;
  logic [ROW_W-1:0]          row1_q;
  logic [COL_W-1:0]          col1_q;

  always_comb begin
    if (depth_i < 0 || depth_i >= $signed(DEPTH_IN_W'(DEPTH_LIMIT))) begin
      d1_d = DEPTH_W'(DEPTH_FAR);
    end else begin
      d1_d = depth_i[DEPTH_W-1:0];
    end
  end

  assign dc_wide = $signed((DELTA_W+1)'({pixel_col_i, 1'b0}))
                 - $signed((DELTA_W+1)'(DEPTH_COLS));
  assign dr_wide = $signed((DELTA_W+1)'({pixel_row_i, 1'b0}))
                 - $signed((DELTA_W+1)'(DEPTH_ROWS));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q   <= d1_d;
      dc1_q  <= dc_wide[DELTA_W-1:0];
      dr1_q  <= dr_wide[DELTA_W-1:0];
      row1_q <= pixel_row_i;
      col1_q <= pixel_col_i;
    end
  end

  // stage 2: offset times depth, colour products
  logic signed [MD_W-1:0] mx2_d, my2_d, mx2_q, my2_q;
  logic [CPROD_W-1:0]     crp2_d, ccp2_d, crp2_q, ccp2_q;
  logic [DEPTH_W-1:0]     d2_q;

  assign mx2_d  = dc1_q * $signed({1'b0, d1_q});
  assign my2_d  = dr1_q * $signed({1'b0, d1_q});
  assign crp2_d = CPROD_W'(row1_q) * CPROD_W'(row_scale_i);
  assign ccp2_d = CPROD_W'(col1_q) * CPROD_W'(col_scale_i);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mx2_q  <= mx2_d;
      my2_q  <= my2_d;
      crp2_q <= crp2_d;
      ccp2_q <= ccp2_d;
      d2_q   <= d1_q;
    end
  end

  // stage 3: times reciprocal focal length, colour rounding
  logic signed [FX_W-1:0] fx3_d, fy3_d, fx3_q, fy3_q;
  color_t                 crow3_q, ccol3_q;
  logic [DEPTH_W-1:0]     d3_q;

  assign fx3_d = mx2_q * $signed({1'b0, inv_focal_i});
  assign fy3_d = my2_q * $signed({1'b0, inv_focal_i});

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      fx3_q   <= fx3_d;
      fy3_q   <= fy3_d;
      crow3_q <= color_round(crp2_q);
      ccol3_q <= color_round(ccp2_q);
      d3_q    <= d2_q;
    end
  end

  // stage 4: round away the Q0.24 and half-pixel fraction
  logic signed [FX_W-1:0] fx_rnd, fy_rnd;
  coord_t                 x4_q, y4_q;
  color_t                 crow4_q, ccol4_q;
  logic [DEPTH_W-1:0]     d4_q;

  assign fx_rnd = fx3_q + $signed(FX_W'(1) << (FOCAL_FRAC - 1));
  assign fy_rnd = fy3_q + $signed(FX_W'(1) << (FOCAL_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x4_q    <= $signed(fx_rnd[FOCAL_FRAC+COORD_W-1:FOCAL_FRAC]);
      y4_q    <= $signed(fy_rnd[FOCAL_FRAC+COORD_W-1:FOCAL_FRAC]);
      crow4_q <= crow3_q;
      ccol4_q <= ccol3_q;
      d4_q    <= d3_q;
    end
  end

  assign pv_o    = (d4_q != '0);
  assign depth_o = d4_q;
  assign x_o     = x4_q;
  assign y_o     = y4_q;
  assign crow_o  = crow4_q;
  assign ccol_o  = ccol4_q;

endmodule
`default_nettype wire

### design/dbrt_xform_row.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrt_xform_row
// One row of the rigid transform: three products, rounded sum, translation
// and saturation to 32 bits, in three register stages.
// ----------------------------------------------------------------------------
module dbrt_xform_row (
  input  logic                                    clk_i,
  input  dbrt_pkg::stage_en_t                     en_i,
  input  logic [dbrt_pkg::ROT_W-1:0]              coef_row_i,
  input  logic signed [dbrt_pkg::TRANS_W-1:0]     trans_i,
  input  dbrt_pkg::coord_t                        x_i,
  input  dbrt_pkg::coord_t                        y_i,
  input  logic [dbrt_pkg::DEPTH_W-1:0]            z_i,
  input  logic                                    keep_i,
  output logic signed [dbrt_pkg::POINT_W-1:0]     point_o
);
  import dbrt_pkg::*;

  logic signed [COEF_W-1:0] c0, c1, c2;

  assign c0 = $signed(coef_row_i[COEF_W-1:0]);
  assign c1 = $signed(coef_row_i[2*COEF_W-1:COEF_W]);
  assign c2 = $signed(coef_row_i[3*COEF_W-1:2*COEF_W]);

  // products
  logic signed [PROD_W-1:0] p0_d, p1_d, p2_d, p0_q, p1_q, p2_q;

  assign p0_d = c0 * x_i;
  assign p1_d = c1 * y_i;
  assign p2_d = c2 * $signed({1'b0, z_i});

  always_ff @(posedge clk_i) begin
    if (en_i[ST_XF_MUL]) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // sum with half an lsb of Q1.16 added for rounding
  logic signed [SUM_W-1:0] s_d, s_q;

  assign s_d = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q)
             + $signed(SUM_W'(1) << (ROT_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[ST_XF_SUM]) begin
      s_q <= s_d;
    end
  end

  // translate and saturate, zero for an item without a point
  logic signed [POINT_W:0]   t_sum;
  logic signed [POINT_W-1:0] pt_d, pt_q;

  assign t_sum = (POINT_W+1)'($signed(s_q[ROT_FRAC+POINT_W-1:ROT_FRAC]))
               + (POINT_W+1)'(trans_i);

  always_comb begin
    if (!keep_i) begin
      pt_d = '0;
    end else if (t_sum[POINT_W] != t_sum[POINT_W-1]) begin
      pt_d = t_sum[POINT_W] ? {1'b1, {(POINT_W-1){1'b0}}} : {1'b0, {(POINT_W-1){1'b1}}};
    end else begin
      pt_d = t_sum[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      pt_q <= pt_d;
    end
  end

  assign point_o = pt_q;

endmodule
`default_nettype wire

### design/depth_backproject_rigid_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_backproject_rigid_transform
// Back-projects depth pixels to 3-D points and applies a rigid transform.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_ready_o) takes one depth pixel per item:
//   row, column and signed Q8.8 depth. out channel (out_valid_o /
//   out_ready_i) returns one item per input item, in order: valid flag,
//   clamped depth, transformed x/y/z (Q23.8, saturated) and colour coords.
//   The pipeline has seven register stages. Throughput is one item per
//   cycle while the receiver does not stall. Registers are to be written
//   through cfg_we_i / cfg_addr_i / cfg_wdata_i by the user only while
//   the pipeline is empty; the block itself does not enforce this.
//   Writes to unused indexes are dropped.
//   Reset empties the pipeline and loads the register defaults (zero matrix,
//   zero translation, zero focal reciprocal, unity colour scales).
//   When the receiver stalls, each stage holds its item; in_ready_o stays
//   high as long as any stage is empty, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module depth_backproject_rigid_transform (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dbrt_pkg::CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [dbrt_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [dbrt_pkg::ROW_W-1:0]             pixel_row_i,
  input  logic [dbrt_pkg::COL_W-1:0]             pixel_col_i,
  input  logic signed [dbrt_pkg::DEPTH_IN_W-1:0] depth_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   point_valid_o,
  output logic [dbrt_pkg::DEPTH_W-1:0]           clamped_depth_o,
  output logic signed [dbrt_pkg::POINT_W-1:0]    point_x_o,
  output logic signed [dbrt_pkg::POINT_W-1:0]    point_y_o,
  output logic signed [dbrt_pkg::POINT_W-1:0]    point_z_o,
  output logic [dbrt_pkg::COLOR_W-1:0]           color_row_o,
  output logic [dbrt_pkg::COLOR_W-1:0]           color_col_o
);
  import dbrt_pkg::*;

  // configuration registers
  logic [ROT_W-1:0]       rot_row0_q, rot_row1_q, rot_row2_q;
  logic [TRANS_REG_W-1:0] translation_q;
  logic [FOCAL_W-1:0]     inv_focal_q;
  logic [SCALE_W-1:0]     row_scale_q, col_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row0_q    <= '0;
      rot_row1_q    <= '0;
      rot_row2_q    <= '0;
      translation_q <= '0;
      inv_focal_q   <= '0;
      row_scale_q   <= SCALE_W'(SCALE_ONE);
      col_scale_q   <= SCALE_W'(SCALE_ONE);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROT_ROW0:    rot_row0_q    <= cfg_wdata_i[ROT_W-1:0];
        REG_ROT_ROW1:    rot_row1_q    <= cfg_wdata_i[ROT_W-1:0];
        REG_ROT_ROW2:    rot_row2_q    <= cfg_wdata_i[ROT_W-1:0];
        REG_TRANSLATION: translation_q <= cfg_wdata_i[TRANS_REG_W-1:0];
        REG_INV_FOCAL:   inv_focal_q   <= cfg_wdata_i[FOCAL_W-1:0];
        REG_ROW_SCALE:   row_scale_q   <= cfg_wdata_i[SCALE_W-1:0];
        REG_COL_SCALE:   col_scale_q   <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits and per-stage ready chain
  logic [NUM_STAGES-1:0] v_d, v_q, v_in;
  logic [NUM_STAGES:0]   rdy;
  stage_en_t             en;

  always_comb begin
    rdy[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in = {v_q[NUM_STAGES-2:0], in_valid_i};
  assign en   = rdy[NUM_STAGES-1:0] & v_in;
  assign v_d  = (rdy[NUM_STAGES-1:0] & v_in) | (~rdy[NUM_STAGES-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  // front end, stages 1 to 4
  logic               pv4;
  logic [DEPTH_W-1:0] d4;
  coord_t             x4, y4;
  color_t             crow4, ccol4;

  dbrt_frontend u_frontend (
    .clk_i       (clk_i),
    .en_i        (en),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .depth_i     (depth_i),
    .inv_focal_i (inv_focal_q),
    .row_scale_i (row_scale_q),
    .col_scale_i (col_scale_q),
    .pv_o        (pv4),
    .depth_o     (d4),
    .x_o         (x4),
    .y_o         (y4),
    .crow_o      (crow4),
    .ccol_o      (ccol4)
  );

  // side data carried alongside the transform stages
  logic               pv5_q, pv6_q, pv7_q;
  logic [DEPTH_W-1:0] d5_q, d6_q, d7_q;
  color_t             crow5_q, crow6_q, crow7_q;
  color_t             ccol5_q, ccol6_q, ccol7_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_XF_MUL]) begin
      pv5_q   <= pv4;
      d5_q    <= d4;
      crow5_q <= crow4;
      ccol5_q <= ccol4;
    end
    if (en[ST_XF_SUM]) begin
      pv6_q   <= pv5_q;
      d6_q    <= d5_q;
      crow6_q <= crow5_q;
      ccol6_q <= ccol5_q;
    end
    if (en[ST_OUT]) begin
      pv7_q   <= pv6_q;
      d7_q    <= d6_q;
      crow7_q <= pv6_q ? crow6_q : '0;
      ccol7_q <= pv6_q ? ccol6_q : '0;
    end
  end

  // three transform rows, z of the camera point is the clamped depth
  dbrt_xform_row u_row_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .coef_row_i (rot_row0_q),
    .trans_i    ($signed(translation_q[TRANS_W-1:0])),
    .x_i        (x4),
    .y_i        (y4),
    .z_i        (d4),
    .keep_i     (pv6_q),
    .point_o    (point_x_o)
  );

  dbrt_xform_row u_row_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .coef_row_i (rot_row1_q),
    .trans_i    ($signed(translation_q[2*TRANS_W-1:TRANS_W])),
    .x_i        (x4),
    .y_i        (y4),
    .z_i        (d4),
    .keep_i     (pv6_q),
    .point_o    (point_y_o)
  );

  dbrt_xform_row u_row_z (
    .clk_i      (clk_i),
    .en_i       (en),
    .coef_row_i (rot_row2_q),
    .trans_i    ($signed(translation_q[3*TRANS_W-1:2*TRANS_W])),
    .x_i        (x4),
    .y_i        (y4),
    .z_i        (d4),
    .keep_i     (pv6_q),
    .point_o    (point_z_o)
  );

  assign point_valid_o   = pv7_q;
  assign clamped_depth_o = d7_q;
  assign color_row_o     = crow7_q;
  assign color_col_o     = ccol7_q;

  // a full pipeline with a stalled receiver takes no new item
  a_no_accept_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> ((v_q != {NUM_STAGES{1'b1}}) || out_ready_i))
    else $error("item accepted into a full stalled pipeline");

  // a held item in the middle of the pipeline is not dropped
  a_mid_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_XF_MUL-1] && !rdy[ST_XF_MUL]) |=> v_q[ST_XF_MUL-1])
    else $error("stalled item lost in pipeline");

  // an item without a point carries zero coordinates
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !point_valid_o) |->
      (point_x_o == '0 && point_y_o == '0 && point_z_o == '0 &&
       color_row_o == '0 && color_col_o == '0))
    else $error("invalid point with nonzero coordinates");

  // point flag follows the clamped depth
  a_valid_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (point_valid_o == (clamped_depth_o != '0)))
    else $error("point flag disagrees with clamped depth");

  // clamped depth is below the limit or the far value
  a_clamp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clamped_depth_o < DEPTH_W'(DEPTH_LIMIT) ||
                     clamped_depth_o == DEPTH_W'(DEPTH_FAR)))
    else $error("clamped depth out of range");

endmodule
`default_nettype wire
